FILE: hdl/prsf_pkg.sv
// Package for the prime-removing stream filter.
// Holds the shared item and status types and fixed constants.
// No dependencies.
`default_nettype none

package prsf_pkg;

  // Width of the value field on both stream sides.
  localparam int unsigned ValueWidth = 16;

  // Entries of the queue between the classifier and the tester.
  localparam int unsigned QueueDepth = 2;

  // Dividend bits resolved per remainder pipeline stage.
  localparam int unsigned StepBits = 4;

  // Class that the front end gives to each word.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DROP,
    KIND_TEST
  } kind_e;

  // One queued item: the masked value and its class.
  typedef struct packed {
    logic [ValueWidth-1:0] value;
    kind_e                 kind;
  } item_t;

  // States of the tester.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_POST
  } back_state_e;

  // Status coming back from the remainder pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
    logic busy;
  } rem_status_t;

endpackage

`default_nettype wire

FILE: hdl/prsf_front.sv
// Front end of the prime-removing stream filter: accepts words, masks and classifies them.
// Depends on prsf_pkg.
`default_nettype none

module prsf_front import prsf_pkg::*; #(
  parameter int unsigned EFF_BITS = 16
) (
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [ValueWidth-1:0] s_tdata_i,   // [15:0] value
  input  wire logic                  full_i,
  output logic                       push_o,
  output item_t                      entry_o
);

  localparam logic [ValueWidth-1:0] ValueMask = ValueWidth'((32'd1 << EFF_BITS) - 32'd1);

  logic [ValueWidth-1:0] masked;
  kind_e                 kind;

  // Take a word whenever the queue has room.
  assign s_tready_o = ~full_i;
  assign push_o     = s_tvalid_i & ~full_i;
  assign masked     = s_tdata_i & ValueMask;

  // Zero, one and even values above two are composite or not prime: pass them.
  // Two and three are prime: drop them. Odd values from five need the test.
  always_comb begin
    priority if (masked < ValueWidth'(2)) begin
      kind = KIND_PASS;
    end else if (masked == ValueWidth'(2) || masked == ValueWidth'(3)) begin
      kind = KIND_DROP;
    end else if (!masked[0]) begin
      kind = KIND_PASS;
    end else begin
      kind = KIND_TEST;
    end
  end

  assign entry_o.value = masked;
  assign entry_o.kind  = kind;

endmodule

`default_nettype wire

FILE: hdl/prsf_queue.sv
// Small register queue between the front end and the tester.
// Depends on prsf_pkg.
`default_nettype none

module prsf_queue import prsf_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      entry_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      entry_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  item_t              slot_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CntBits'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/prsf_rem_pipe.sv
// Pipelined restoring remainder unit: one divisor enters per cycle.
// Each stage resolves StepBits dividend bits. Depends on prsf_pkg.
`default_nettype none

module prsf_rem_pipe import prsf_pkg::*; #(
  parameter int unsigned DIVIDEND_BITS = 16,
  parameter int unsigned DIVISOR_BITS  = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [DIVIDEND_BITS-1:0] dividend_i,
  input  wire logic [DIVISOR_BITS-1:0]  divisor_i,
  output rem_status_t                   status_o
);

  localparam int unsigned NumStages = (DIVIDEND_BITS + StepBits - 1) / StepBits;
  localparam int unsigned PadBits   = NumStages * StepBits;
  localparam int unsigned RemBits   = DIVISOR_BITS + 1;

  logic                    vld_q [NumStages];
  logic [RemBits-1:0]      rem_q [NumStages];
  logic [PadBits-1:0]      num_q [NumStages];
  logic [DIVISOR_BITS-1:0] div_q [NumStages];

  logic                    in_vld [NumStages];
  logic [RemBits-1:0]      in_rem [NumStages];
  logic [PadBits-1:0]      in_num [NumStages];
  logic [DIVISOR_BITS-1:0] in_div [NumStages];
  logic [RemBits-1:0]      nxt_rem [NumStages];
  logic                    any_vld;

  // Shift in one dividend bit at a time and subtract the divisor when it fits.
  function automatic logic [RemBits-1:0] step_chunk(
    input logic [RemBits-1:0]      r_in,
    input logic [StepBits-1:0]     bits,
    input logic [DIVISOR_BITS-1:0] d
  );
    logic [RemBits-1:0] r;
    r = r_in;
    for (int k = StepBits - 1; k >= 0; k--) begin
      r = {r[RemBits-2:0], bits[k]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
    end
    return r;
  endfunction

  // Stage inputs: the first stage takes the new divisor, the rest chain.
  always_comb begin
    in_vld[0] = valid_i;
    in_rem[0] = '0;
    in_num[0] = PadBits'(dividend_i);
    in_div[0] = divisor_i;
    for (int s = 1; s < NumStages; s++) begin
      in_vld[s] = vld_q[s-1];
      in_rem[s] = rem_q[s-1];
      in_num[s] = num_q[s-1];
      in_div[s] = div_q[s-1];
    end
    for (int s = 0; s < NumStages; s++) begin
      nxt_rem[s] = step_chunk(in_rem[s], in_num[s][PadBits-1-s*StepBits -: StepBits], in_div[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStages; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NumStages; s++) begin
        vld_q[s] <= in_vld[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStages; s++) begin
      rem_q[s] <= nxt_rem[s];
      num_q[s] <= in_num[s];
      div_q[s] <= in_div[s];
    end
  end

  // Any divisor still in flight keeps the unit busy.
  always_comb begin
    any_vld = 1'b0;
    for (int s = 0; s < NumStages; s++) begin
      any_vld = any_vld | vld_q[s];
    end
  end

  assign status_o.valid = vld_q[NumStages-1];
  assign status_o.zero  = (rem_q[NumStages-1] == '0);
  assign status_o.busy  = any_vld;

endmodule

`default_nettype wire

FILE: hdl/prsf_back.sv
// Tester of the prime-removing stream filter: runs trial division on queued items
// and holds the output register. Depends on prsf_pkg and prsf_rem_pipe.
`default_nettype none

module prsf_back import prsf_pkg::*; #(
  parameter int unsigned EFF_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  item_t                      q_entry_i,
  output logic                       q_pop_o,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [ValueWidth-1:0]      m_tdata_o    // [15:0] kept_value
);

  // Divisors do not exceed the square root of the largest value.
  localparam int unsigned DivBits = (EFF_BITS + 1) / 2;
  localparam int unsigned SqBits  = 2 * DivBits + 1;

  back_state_e           state_q, state_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic [DivBits:0]      div_q, div_d;
  logic [SqBits-1:0]     sq_q, sq_d;
  logic                  hit_q, hit_d;
  logic                  issue;
  logic                  load;
  logic                  out_valid_q;
  logic [ValueWidth-1:0] out_data_q;
  rem_status_t           rem_st;

  // Remainder pipeline takes one odd divisor per cycle.
  prsf_rem_pipe #(
    .DIVIDEND_BITS(EFF_BITS),
    .DIVISOR_BITS (DivBits)
  ) u_rem_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (issue),
    .dividend_i(value_q[EFF_BITS-1:0]),
    .divisor_i (div_q[DivBits-1:0]),
    .status_o  (rem_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
  end

  // Next state: take an item, try odd divisors while d*d <= n, post if not prime.
  always_comb begin
    state_d = state_q;
    value_d = value_q;
    div_d   = div_q;
    sq_d    = sq_q;
    hit_d   = hit_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    issue   = (state_q == ST_TEST) && !hit_q && (sq_q <= SqBits'(value_q));
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          value_d = q_entry_i.value;
          unique case (q_entry_i.kind)
            KIND_PASS: begin
              state_d = ST_POST;
            end
            KIND_TEST: begin
              div_d   = (DivBits + 1)'(3);
              sq_d    = SqBits'(9);
              hit_d   = 1'b0;
              state_d = ST_TEST;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_TEST: begin
        if (issue) begin
          // (d + 2)^2 = d^2 + 4d + 4
          div_d = div_q + (DivBits + 1)'(2);
          sq_d  = sq_q + SqBits'({div_q, 2'b00}) + SqBits'(4);
        end
        if (rem_st.valid && rem_st.zero) begin
          hit_d = 1'b1;
        end
        if (!issue && !rem_st.busy) begin
          state_d = hit_q ? ST_POST : ST_IDLE;
        end
      end
      ST_POST: begin
        if (!out_valid_q || m_tready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register parts the tester from the receiver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= value_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

`default_nettype wire

FILE: hdl/prime_removing_stream_filter_core.sv
// Prime-removing stream filter: drops prime words and passes all others in order.
// Uses the input slave stream (s_tvalid_i, s_tready_o, s_tdata_i) and the output
// master stream (m_tvalid_o, m_tready_i, m_tdata_o); a word moves on a cycle where
// tvalid and tready are both high. Only the low VALUE_BITS bits of a word count.
// Zero and one are passed; two and three are dropped.
// The front end classifies a word in its accept cycle and places it in a two-entry
// queue, so it keeps taking words while the tester works. Even words and the small
// values skip the test. Odd words from five are tested with odd divisors from 3 up
// while d*d <= n, one divisor per cycle through a remainder pipeline of
// ceil(VALUE_BITS/4) stages.
// The divisor sweep is what sets the throughput; the tester handles one word at a time.
// A registered output holds a result while the receiver stalls; the tester then waits,
// and input is held off only once the queue is full.
// Reset clears the queue, the tester state and the output valid flag.
`default_nettype none

module prime_removing_stream_filter_core import prsf_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [ValueWidth-1:0] s_tdata_i,   // [15:0] value
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic [ValueWidth-1:0]      m_tdata_o    // [15:0] kept_value
);

  // Bits above the value field cannot arrive, so the test width stops at it.
  localparam int unsigned EffBits = (VALUE_BITS < ValueWidth) ? VALUE_BITS : ValueWidth;

  logic  push;
  logic  full;
  item_t push_entry;
  logic  q_valid;
  item_t q_entry;
  logic  q_pop;

  prsf_front #(
    .EFF_BITS(EffBits)
  ) u_front (
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  prsf_queue #(
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  prsf_back #(
    .EFF_BITS(EffBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o)
  );

endmodule

`default_nettype wire
